### rtl/core/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg: shared types for the set-associative LRU cache model
// Holds the request and result payload structs, the opcode codes and the
// cache geometry that the address layout fixes.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Address bits 3:1 select the set and bits 15:4 form the tag.
  localparam int SET_COUNT = 8;
  localparam int TAG_SLOTS = 4096;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       data_valid;
    logic       hit;
    logic       dirty;
  } rsp_t;

endpackage

### rtl/core/salc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_ram: generic simple dual-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/set_assoc_lru_cache_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_core: byte cache model with per-set recency list
// Sequencer walking one shared tag comparator over the recency list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset the block
// first runs a clearing pass over the valid, dirty and recency-list memories,
// one entry per cycle with busy high. Each request then walks the recency list
// of its set through one shared tag comparator, one entry per cycle, and
// rewrites the list in the same pass: each entry takes the old value of the one
// above it until the requested tag turns up, so the tag ends up at the front.
// A hit in the resident ways ends the walk at its position; a miss walks all
// LIST_DEPTH entries and, during the walk, clears the dirty bit of every
// non-empty entry past the resident ways on the single dirty port. On a write,
// the S_SHFT state then writes the byte, its valid flag and the dirty bit; a
// read instead passes through S_SHFT, S_RD, S_RD2 and S_OUT for the registered
// memory read and the result. The next request can be taken in the first cycle
// with busy low. A read produces one result, shown for exactly one cycle with
// out_valid in its last busy cycle; the receiver cannot stall it. A write
// produces no result. The recency lists, bytes, byte valid flags and dirty bits
// all sit in RAMs. SET_COUNT and TAG_SLOTS follow from the address layout and
// come from the package.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
#(
  parameter int LIST_DEPTH = 10,
  parameter int WAY_COUNT  = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  localparam int TW     = $clog2(TAG_SLOTS);
  localparam int SW     = $clog2(SET_COUNT);
  localparam int LPW    = $clog2(LIST_DEPTH);
  localparam int LA     = SW + LPW;
  localparam int LDEPTH = SET_COUNT * (1 << LPW);
  localparam int LINES  = SET_COUNT * TAG_SLOTS;
  localparam int LW     = $clog2(LINES);
  localparam int BW     = LW + 1;
  localparam int WAYS   = (WAY_COUNT < LIST_DEPTH) ? WAY_COUNT : LIST_DEPTH;

  typedef enum logic [6:0] {
    S_CLR  = 7'b000_0001,
    S_IDLE = 7'b000_0010,
    S_SCAN = 7'b000_0100,
    S_SHFT = 7'b000_1000,
    S_RD   = 7'b001_0000,
    S_RD2  = 7'b010_0000,
    S_OUT  = 7'b100_0000
  } state_t;

  typedef struct packed {
    logic          used;
    logic [TW-1:0] tag;
  } entry_t;

  state_t state_r, state_nxt;

  req_t           req_r;
  logic [SW-1:0]  set_r;
  logic [TW-1:0]  tagq_r;
  logic [LPW-1:0] pos_r;
  entry_t         carry_r;
  logic           done_r;
  logic           hit_r;
  logic [BW-1:0]  clr_r;
  logic           outv_r;
  rsp_t           rsp_r;

  // Set and tag extraction (modulo the set and tag counts).
  logic [2:0]    set_raw;
  logic [11:0]   tag_raw;
  logic [SW-1:0] set_in;
  logic [TW-1:0] tag_in;
  assign set_raw = in_req.address[3:1];
  assign tag_raw = in_req.address[15:4];
  assign set_in  = SW'(32'(set_raw) % SET_COUNT);
  assign tag_in  = TW'(32'(tag_raw) % TAG_SLOTS);

  logic [LW-1:0] line_w;
  logic [BW-1:0] byte_w;
  assign line_w = LW'(32'(set_r) * TAG_SLOTS + 32'(tagq_r));
  assign byte_w = {line_w, req_r.address[0]};

  // Shared comparator on the list entry read in the previous cycle.
  entry_t l_rd;
  logic   cmp_eq;
  logic   in_ways;
  logic   last_pos;
  assign cmp_eq   = l_rd.used && (l_rd.tag == tagq_r);
  assign in_ways  = (32'(pos_r) < WAYS);
  assign last_pos = (32'(pos_r) == LIST_DEPTH - 1);

  // RAM ports.
  logic          b_we, v_we, d_we, l_we;
  logic [BW-1:0] b_addr;
  logic [LW-1:0] d_addr;
  logic [LA-1:0] l_waddr, l_raddr;
  entry_t        l_wd;
  logic [7:0]    b_rd;
  logic [0:0]    v_rd, d_rd, v_wd, d_wd;

  always_comb begin
    b_we    = 1'b0;
    v_we    = 1'b0;
    d_we    = 1'b0;
    l_we    = 1'b0;
    b_addr  = byte_w;
    d_addr  = line_w;
    v_wd    = 1'b1;
    d_wd    = 1'b1;
    l_waddr = {set_r, pos_r};
    l_raddr = {set_r, LPW'(pos_r + 1'b1)};
    l_wd    = carry_r;
    unique case (state_r)
      S_CLR: begin
        v_we    = 1'b1;
        v_wd    = 1'b0;
        b_addr  = clr_r;
        d_we    = clr_r[0];
        d_addr  = clr_r[BW-1:1];
        d_wd    = 1'b0;
        l_we    = 1'b1;
        l_waddr = clr_r[LA-1:0];
        l_wd    = '0;
      end
      S_IDLE: begin
        // Fetch the front entry so the walk can start right after accept.
        l_raddr = {set_in, {LPW{1'b0}}};
      end
      S_SCAN: begin
        // Until the tag is found, each entry takes the one above it.
        l_we = !done_r;
        // Past the resident ways this is a miss: forget the line's dirty bit.
        if (!in_ways) begin
          d_addr = LW'(32'(set_r) * TAG_SLOTS + 32'(l_rd.tag));
          d_we   = l_rd.used;
          d_wd   = 1'b0;
        end
      end
      S_SHFT: begin
        b_we = (req_r.opcode == OP_WRITE);
        v_we = (req_r.opcode == OP_WRITE);
        d_we = (req_r.opcode == OP_WRITE);
      end
      default: ;
    endcase
  end

  salc_ram #(.WIDTH(8), .DEPTH(2 * LINES)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_addr), .wdata(req_r.write_data),
    .raddr(b_addr), .rdata(b_rd));
  salc_ram #(.WIDTH(1), .DEPTH(2 * LINES)) u_bval (
    .clk(clk), .we(v_we), .waddr(b_addr), .wdata(v_wd), .raddr(b_addr), .rdata(v_rd));
  salc_ram #(.WIDTH(1), .DEPTH(LINES)) u_dirty (
    .clk(clk), .we(d_we), .waddr(d_addr), .wdata(d_wd), .raddr(d_addr), .rdata(d_rd));
  salc_ram #(.WIDTH(TW + 1), .DEPTH(LDEPTH)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wd), .raddr(l_raddr), .rdata(l_rd));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == BW'(2 * LINES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if ((cmp_eq && in_ways) || last_pos) state_nxt = S_SHFT;
      S_SHFT: state_nxt = (req_r.opcode == OP_WRITE) ? S_IDLE : S_RD;
      S_RD:   state_nxt = S_RD2;
      S_RD2:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= 1'b0;
      unique case (state_r)
        S_CLR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          req_r        <= in_req;
          set_r        <= set_in;
          tagq_r       <= tag_in;
          pos_r        <= '0;
          carry_r.used <= 1'b1;
          carry_r.tag  <= tag_in;
          done_r       <= 1'b0;
          hit_r        <= 1'b0;
        end
        S_SCAN: begin
          if (!done_r) begin
            carry_r <= l_rd;
          end
          // The matching entry is dropped; everything below it stays put.
          if (cmp_eq) begin
            done_r <= 1'b1;
            if (in_ways) begin
              hit_r <= 1'b1;
            end
          end
          pos_r <= pos_r + 1'b1;
        end
        S_RD2: begin
          rsp_r.read_data  <= v_rd[0] ? b_rd : 8'd0;
          rsp_r.data_valid <= v_rd[0];
          rsp_r.hit        <= hit_r;
          rsp_r.dirty      <= hit_r && v_rd[0] && d_rd[0];
          outv_r           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = outv_r;
  assign out_rsp   = rsp_r;

  // A result follows only the read stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_RD2))
    else $error("result outside read stage");
  // Dirty is only reported on a hit with valid data.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.dirty |-> (out_rsp.hit && out_rsp.data_valid))
    else $error("dirty reported without valid hit");
  // The recency list is only written while clearing or walking.
  assert property (@(posedge clk) disable iff (!rst_n)
    l_we |-> (state_r == S_CLR || state_r == S_SCAN))
    else $error("list write outside walk");
  // The walk never leaves the list.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(pos_r) < LIST_DEPTH))
    else $error("walk past list end");
  // Past the resident ways the request is always a miss.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !in_ways) |-> !hit_r)
    else $error("hit flagged outside resident ways");

endmodule

### dv/tb_set_assoc_lru_cache_model_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_model_core: self-checking bench for the LRU cache core
// A driver sends read and write requests from a pending queue, with random
// idle gaps. A cycle-accurate-free predictor keeps its own recency lists,
// byte store and dirty bits, and queues the expected read responses. A
// monitor compares every response field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_model_core;
  import salc_pkg::*;

  localparam int NSETS  = 8;
  localparam int DEPTH  = 10;
  localparam int NWAYS  = 3;
  localparam int NTAGS  = 4096;
  localparam int LIMIT  = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_valid;
  rsp_t out_rsp;

  always #5 clk = ~clk;

  set_assoc_lru_cache_model_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  // Predictor state: recency lists, byte store with valid flags, dirty bits.
  logic [11:0] rec_tag [NSETS][DEPTH];
  logic        rec_used[NSETS][DEPTH];
  logic [7:0]  bytes   [int];
  logic        dirty_bits[int];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  bit   failed = 1'b0;
  bit   feed_done = 1'b0;
  bit   calm = 1'b0;
  int   cycles = 0;

  // Apply one accepted request to the cache image; push a response for reads.
  task automatic cache_access(input req_t r);
    int set, tg, line, bix, found, k;
    bit hit, valid;
    rsp_t e;
    set = int'(r.address[3:1]);
    tg = int'(r.address[15:4]);
    line = set * NTAGS + tg;
    bix = line * 2 + int'(r.address[0]);
    hit = 1'b0;
    found = -1;
    for (int i = 0; i < NWAYS; i++)
      if (rec_used[set][i] && int'(rec_tag[set][i]) == tg) begin
        hit = 1'b1;
        found = i;
      end
    // A miss forgets the dirty state of every non-empty history entry.
    if (!hit) begin
      for (int i = NWAYS; i < DEPTH; i++) begin
        if (!rec_used[set][i]) continue;
        if (int'(rec_tag[set][i]) == tg) found = i;
        dirty_bits[set * NTAGS + int'(rec_tag[set][i])] = 1'b0;
      end
    end
    k = (found >= 0) ? found : DEPTH - 1;
    for (; k > 0; k--) begin
      rec_tag[set][k] = rec_tag[set][k-1];
      rec_used[set][k] = rec_used[set][k-1];
    end
    rec_tag[set][0] = 12'(tg);
    rec_used[set][0] = 1'b1;
    if (r.opcode == OP_WRITE) begin
      bytes[bix] = r.write_data;
      dirty_bits[line] = 1'b1;
    end else begin
      valid = bytes.exists(bix);
      e.read_data = valid ? bytes[bix] : 8'h00;
      e.data_valid = valid;
      e.hit = hit;
      e.dirty = (hit && valid && dirty_bits.exists(line)) ? dirty_bits[line] : 1'b0;
      expected_rsps.push_back(e);
    end
  endtask

  // Driver: start stays high while busy and between back-to-back requests.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        cache_access(in_req);
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
          in_req <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_reqs.size() > 0
                   && (calm || $urandom_range(99) >= 31)) begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: responses cannot be held off, so each one is checked as it shows.
  always @(posedge clk) begin
    rsp_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", out_rsp);
        failed = 1'b1;
      end else begin
        e = expected_rsps.pop_front();
        if (out_rsp.read_data !== e.read_data) begin
          $error("read_data expected %0h actual %0h", e.read_data, out_rsp.read_data);
          failed = 1'b1;
        end
        if (out_rsp.data_valid !== e.data_valid) begin
          $error("data_valid expected %0b actual %0b", e.data_valid, out_rsp.data_valid);
          failed = 1'b1;
        end
        if (out_rsp.hit !== e.hit) begin
          $error("hit expected %0b actual %0b", e.hit, out_rsp.hit);
          failed = 1'b1;
        end
        if (out_rsp.dirty !== e.dirty) begin
          $error("dirty expected %0b actual %0b", e.dirty, out_rsp.dirty);
          failed = 1'b1;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAIL set_assoc_lru_cache_model_core");
      $finish;
    end
  end

  function automatic req_t mk(input logic op, input logic [15:0] a, input logic [7:0] d);
    req_t r;
    r.opcode = op;
    r.address = a;
    r.write_data = d;
    return r;
  endfunction

  initial begin
    int base_set, n;
    logic [11:0] tags[6];
    for (int s = 0; s < NSETS; s++)
      for (int i = 0; i < DEPTH; i++) begin
        rec_tag[s][i] = '0;
        rec_used[s][i] = 1'b0;
      end
    // Directed: address extremes, read never-written, write then hit.
    pending_reqs.push_back(mk(OP_READ, 16'h0000, 8'hA5));
    pending_reqs.push_back(mk(OP_WRITE, 16'h0000, 8'hFF));
    pending_reqs.push_back(mk(OP_READ, 16'h0000, 8'h00));
    pending_reqs.push_back(mk(OP_READ, 16'h0001, 8'h00));
    pending_reqs.push_back(mk(OP_WRITE, 16'hFFFF, 8'h00));
    pending_reqs.push_back(mk(OP_READ, 16'hFFFF, 8'hFF));
    // Evict tag 0 of set 0 with three others, then read it back (valid miss).
    for (int t = 1; t <= 3; t++) pending_reqs.push_back(mk(OP_WRITE, 16'(t << 4), 8'(t)));
    pending_reqs.push_back(mk(OP_READ, 16'h0000, 8'h00));
    pending_reqs.push_back(mk(OP_READ, 16'h0010, 8'h00));
    // Overflow the history so the oldest entries fall off.
    for (int t = 4; t <= 14; t++) pending_reqs.push_back(mk(OP_READ, 16'(t << 4), 8'h00));
    pending_reqs.push_back(mk(OP_READ, 16'h0010, 8'h00));
    // Random part: mostly a small working set per burst, so hits, history
    // hits and dirty clearing all occur; some fully random noise.
    n = 0;
    while (n < 800) begin
      if ($urandom_range(9) < 2) begin
        pending_reqs.push_back(mk(1'($urandom), 16'($urandom), 8'($urandom)));
        n++;
      end else begin
        base_set = $urandom_range(NSETS - 1);
        foreach (tags[i]) tags[i] = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
        repeat (12) begin
          pending_reqs.push_back(mk(1'($urandom), {tags[$urandom_range(5)], 3'(base_set),
                                     1'($urandom)}, 8'($urandom)));
          n++;
        end
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Long stretch without idling in the middle of the random part.
    wait (pending_reqs.size() < 500);
    calm = 1'b1;
    wait (pending_reqs.size() < 350);
    calm = 1'b0;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_rsps.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed && expected_rsps.size() == 0) begin
      $display("PASS set_assoc_lru_cache_model_core");
    end else begin
      $display("FAIL set_assoc_lru_cache_model_core");
    end
    $finish;
  end

endmodule
